// File: rtl/core/fragment_reassembly_tracker_unit_macros.svh
// Assertion macros shared by the checking code of the tracker.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define FRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/frt_pkg.sv
`default_nettype none
package frt_pkg;

  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned MAX_PIECES = 16;
  localparam int unsigned PIECE_W    = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [31:0] EXPIRY_RESET = 32'd1000000000;
  localparam logic [PADDR_W-1:0] REG_EXPIRY_WINDOW = '0;

  localparam logic [2:0] STAT_PENDING  = 3'd0;
  localparam logic [2:0] STAT_PIECE    = 3'd1;
  localparam logic [2:0] STAT_SHORT    = 3'd2;
  localparam logic [2:0] STAT_BUSY     = 3'd3;
  localparam logic [2:0] STAT_DUP      = 3'd4;
  localparam logic [2:0] STAT_OVERLAP  = 3'd5;
  localparam logic [2:0] STAT_FULL     = 3'd6;
  localparam logic [2:0] STAT_NOT_FRAG = 3'd7;

  typedef enum logic [1:0] {
    AGE_NOP    = 2'd0,
    AGE_REMOVE = 2'd1,
    AGE_APPEND = 2'd2,
    AGE_MOVE   = 2'd3
  } age_op_e;

  typedef struct packed {
    age_op_e           op;
    logic [SLOT_W-1:0] slot;
  } age_cmd_t;

  typedef struct packed {
    logic [15:0]      id;
    logic [16:0]      received;
    logic [16:0]      total;
    logic [31:0]      stamp;
    logic [CNT_W-1:0] count;
  } slot_rec_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic [15:0] handle;
  } piece_t;

endpackage
`default_nettype wire

// File: rtl/core/frt_ram.sv
`default_nettype none
module frt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/frt_age_list.sv
`default_nettype none
module frt_age_list (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire frt_pkg::age_cmd_t              cmd_i,
  output logic      [frt_pkg::SLOT_W-1:0]     head_o,
  output logic      [frt_pkg::CNT_W-1:0]      count_o
);
  import frt_pkg::*;

  // Slots in least-recently-updated order, oldest at position zero.
  logic [SLOT_W-1:0] order_q [NUM_SLOTS];
  logic [SLOT_W-1:0] order_d [NUM_SLOTS];
  logic [SLOT_W-1:0] rm      [NUM_SLOTS];
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_rm;
  logic [NUM_SLOTS-1:0] hit, at_or_after;
  logic found, do_rm, do_app;

  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      hit[j] = (CNT_W'(j) < cnt_q) && (order_q[j] == cmd_i.slot);
    end
    at_or_after[0] = hit[0];
    for (int j = 1; j < NUM_SLOTS; j++) begin
      at_or_after[j] = at_or_after[j-1] | hit[j];
    end
    found = |hit;
    for (int j = 0; j < NUM_SLOTS - 1; j++) begin
      rm[j] = at_or_after[j] ? order_q[j+1] : order_q[j];
    end
    rm[NUM_SLOTS-1] = order_q[NUM_SLOTS-1];

    do_rm  = (cmd_i.op == AGE_REMOVE) || (cmd_i.op == AGE_MOVE);
    do_app = (cmd_i.op == AGE_APPEND) || (cmd_i.op == AGE_MOVE);

    cnt_rm = (do_rm && found) ? cnt_q - CNT_W'(1) : cnt_q;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      order_d[j] = (do_rm && found) ? rm[j] : order_q[j];
    end
    cnt_d = cnt_rm;
    if (do_app && (cnt_rm < CNT_W'(NUM_SLOTS))) begin
      order_d[cnt_rm[SLOT_W-1:0]] = cmd_i.slot;
      cnt_d = cnt_rm + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      order_q[j] <= order_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = order_q[0];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

// File: rtl/core/fragment_reassembly_tracker_unit.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata: id, offset, header words, length,
//                                          stamp, tag; tuser: is_fragment; tlast: last_flag
// m_axis    out  tvalid/tready             tdata: slot, tag, offset, length, total,
//                                          evicted, evicted id; tuser: status; tlast
// apb       in   psel/penable/pready       expiry_window at byte address 0
//
// An accepted word passes the ageing check and the slot lookup; one that goes on then
// runs a sorted search of the stored pieces and a decision that may end it as a
// duplicate, overlap or full slot, then a shift of pieces to open a gap, the insert and,
// on completion, one result per piece, as the piece memory yields one entry per cycle.
// The next word is taken once the last result sits in the output register, which parts
// the two sides; a stalled output holds the sequencer. Reset clears flags and age list.
`default_nettype none
module fragment_reassembly_tracker_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input words.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [15:0] frag_id, [31:16] byte_offset, [36:32] header_words, [52:37] packet_len,
  // [84:53] time_stamp, [100:85] buffer_tag
  input  wire logic [103:0] s_axis_tdata,
  // [0] is_fragment
  input  wire logic         s_axis_tuser,
  input  wire logic         s_axis_tlast,
  // Result words.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [3:0] slot, [19:4] out_tag, [35:20] piece_offset_out, [51:36] piece_length_out,
  // [68:52] total_length, [69] evicted, [85:70] evicted_id
  output logic      [87:0]  m_axis_tdata,
  // [2:0] status
  output logic      [2:0]   m_axis_tuser,
  output logic              m_axis_tlast,
  // Configuration.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [frt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import frt_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_AGE     = 10'b00_0000_0010,
    ST_SLOT    = 10'b00_0000_0100,
    ST_SCAN    = 10'b00_0000_1000,
    ST_DECIDE  = 10'b00_0001_0000,
    ST_SHIFT   = 10'b00_0010_0000,
    ST_INSERT  = 10'b00_0100_0000,
    ST_EMIT_RD = 10'b00_1000_0000,
    ST_EMIT_LD = 10'b01_0000_0000,
    ST_RESULT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration register; pready is tied high, so a write lands in the access cycle.
  logic [31:0] window_q;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_EXPIRY_WINDOW) ? window_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= EXPIRY_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_EXPIRY_WINDOW)) begin
      window_q <= pwdata;
    end
  end

  // Captured input word. The body length is worked out at capture time.
  logic        frag_q, last_q, short_q;
  logic [15:0] id_q, off_q, len_q, tag_q;
  logic [31:0] ts_q;
  logic [SLOT_W-1:0] sl;
  logic [16:0] hbytes_in, plen_in;
  assign sl = id_q[SLOT_W-1:0];
  assign hbytes_in = {10'd0, s_axis_tdata[36:32], 2'b00};
  assign plen_in   = {1'b0, s_axis_tdata[52:37]};

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frag_q  <= s_axis_tuser;
      id_q    <= s_axis_tdata[15:0];
      off_q   <= s_axis_tdata[31:16];
      len_q   <= 16'(plen_in - hbytes_in);
      short_q <= plen_in < hbytes_in;
      last_q  <= s_axis_tlast;
      ts_q    <= s_axis_tdata[84:53];
      tag_q   <= s_axis_tdata[100:85];
    end
  end

  // Per-slot flags live in flip-flops so that reset clears them at once.
  logic [NUM_SLOTS-1:0] valid_q, valid_d, seen_q, seen_d;

  // Age list.
  age_cmd_t age_cmd;
  logic [SLOT_W-1:0] age_head;
  logic [CNT_W-1:0]  age_cnt;

  frt_age_list u_age (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (age_cmd),
    .head_o  (age_head),
    .count_o (age_cnt)
  );

  // Slot record memory.
  logic              rec_we, rec_re;
  logic [SLOT_W-1:0] rec_raddr;
  slot_rec_t         rec_wdata, rec_rdata;

  frt_ram #(.Width($bits(slot_rec_t)), .Depth(NUM_SLOTS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (sl),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  // Piece memory, one row of MAX_PIECES entries per slot, kept sorted by offset.
  logic               pc_we, pc_re;
  logic [PIECE_W-1:0] pc_widx, pc_ridx;
  piece_t             pc_wdata, pc_rdata;

  frt_ram #(.Width($bits(piece_t)), .Depth(NUM_SLOTS * MAX_PIECES)) u_piece_ram (
    .clk_i   (clk_i),
    .we_i    (pc_we),
    .waddr_i ({sl, pc_widx}),
    .wdata_i (pc_wdata),
    .re_i    (pc_re),
    .raddr_i ({sl, pc_ridx}),
    .rdata_o (pc_rdata)
  );

  // Working registers of the sequencer.
  slot_rec_t        rec_q, rec_d;
  logic [CNT_W-1:0] c_q, c_d, i_q, i_d, k_q, k_d;
  piece_t           prev_q, prev_d, succ_q, succ_d;
  logic [2:0]       status_q, status_d;
  logic [16:0]      total_q, total_d;
  logic             ev_q, ev_d;
  logic [15:0]      evid_q, evid_d;

  // Output register.
  logic        out_vld_q, out_load;
  logic [87:0] out_data_q, out_data_d;
  logic [2:0]  out_user_q, out_user_d;
  logic        out_last_q, out_last_d;
  logic        out_free;
  assign out_free = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // Ageing distance, taken the short way round the 32-bit wrap.
  logic [31:0] age_d, age_dist;
  assign age_d    = ts_q - rec_rdata.stamp;
  assign age_dist = (age_d <= 32'h8000_0000) ? age_d : (32'd0 - age_d);

  // Placement checks against the neighbors found by the search.
  logic        has_succ, is_dup, is_ovl;
  logic [16:0] prev_end, new_end;
  assign has_succ = i_q < c_q;
  assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.size};
  assign new_end  = {1'b0, off_q} + {1'b0, len_q};
  assign is_dup   = has_succ && (succ_q.start == off_q);
  assign is_ovl   = ((i_q != '0) && (prev_end > {1'b0, off_q})) ||
                    (has_succ && (new_end > {1'b0, succ_q.start}));

  logic [16:0] recv_new, total_new;
  logic        seen_new;
  assign recv_new  = rec_q.received + {1'b0, len_q};
  assign total_new = last_q ? new_end : rec_q.total;
  assign seen_new  = last_q || seen_q[sl];

  logic zero_piece;
  assign zero_piece = (status_q == STAT_SHORT) || (status_q == STAT_NOT_FRAG);

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    seen_d     = seen_q;
    age_cmd    = '{op: AGE_NOP, slot: sl};
    rec_we     = 1'b0;
    rec_re     = 1'b0;
    rec_raddr  = sl;
    rec_wdata  = rec_q;
    pc_we      = 1'b0;
    pc_re      = 1'b0;
    pc_widx    = k_q[PIECE_W-1:0];
    pc_ridx    = '0;
    pc_wdata   = pc_rdata;
    rec_d      = rec_q;
    c_d        = c_q;
    i_d        = i_q;
    k_d        = k_q;
    prev_d     = prev_q;
    succ_d     = succ_q;
    status_d   = status_q;
    total_d    = total_q;
    ev_d       = ev_q;
    evid_d     = evid_q;
    out_load   = 1'b0;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;

    case (state_q)
      ST_IDLE: begin
        // Keep the oldest slot's record in flight for the ageing check.
        rec_re    = 1'b1;
        rec_raddr = age_head;
        if (in_acc) begin
          state_d = ST_AGE;
        end
      end

      ST_AGE: begin
        ev_d   = 1'b0;
        evid_d = '0;
        if ((age_cnt != '0) && (age_dist > window_q)) begin
          ev_d              = 1'b1;
          evid_d            = rec_rdata.id;
          valid_d[age_head] = 1'b0;
          seen_d[age_head]  = 1'b0;
          age_cmd           = '{op: AGE_REMOVE, slot: age_head};
        end
        rec_re    = 1'b1;
        rec_raddr = sl;
        state_d   = ST_SLOT;
      end

      ST_SLOT: begin
        i_d = '0;
        if (!frag_q) begin
          status_d = STAT_NOT_FRAG;
          state_d  = ST_RESULT;
        end else if (short_q) begin
          status_d = STAT_SHORT;
          state_d  = ST_RESULT;
        end else if (valid_q[sl] && (rec_rdata.id != id_q)) begin
          status_d = STAT_BUSY;
          state_d  = ST_RESULT;
        end else begin
          if (valid_q[sl]) begin
            rec_d = rec_rdata;
            c_d   = (rec_rdata.count > CNT_W'(MAX_PIECES)) ? CNT_W'(MAX_PIECES)
                                                            : rec_rdata.count;
          end else begin
            // A fresh slot opens empty and joins the age list as youngest.
            rec_d       = '{id: id_q, received: '0, total: '0, stamp: ts_q, count: '0};
            c_d         = '0;
            valid_d[sl] = 1'b1;
            seen_d[sl]  = 1'b0;
            age_cmd     = '{op: AGE_APPEND, slot: sl};
          end
          if (valid_q[sl] && (rec_rdata.count != '0)) begin
            pc_re   = 1'b1;
            pc_ridx = '0;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_SCAN: begin
        // One stored piece per cycle until the first offset not below the new one.
        if (pc_rdata.start < off_q) begin
          prev_d = pc_rdata;
          i_d    = i_q + CNT_W'(1);
          if ((i_q + CNT_W'(1)) < c_q) begin
            pc_re   = 1'b1;
            pc_ridx = PIECE_W'(i_q + CNT_W'(1));
          end else begin
            state_d = ST_DECIDE;
          end
        end else begin
          succ_d  = pc_rdata;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (is_dup) begin
          status_d = STAT_DUP;
          state_d  = ST_RESULT;
        end else if (is_ovl) begin
          valid_d[sl] = 1'b0;
          seen_d[sl]  = 1'b0;
          age_cmd     = '{op: AGE_REMOVE, slot: sl};
          status_d    = STAT_OVERLAP;
          state_d     = ST_RESULT;
        end else if (c_q >= CNT_W'(MAX_PIECES)) begin
          status_d = STAT_FULL;
          state_d  = ST_RESULT;
        end else begin
          k_d = c_q;
          if (c_q > i_q) begin
            pc_re   = 1'b1;
            pc_ridx = PIECE_W'(c_q - CNT_W'(1));
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_INSERT;
          end
        end
      end

      ST_SHIFT: begin
        // Move piece k-1 up to k; the next read is issued in the same cycle.
        pc_we    = 1'b1;
        pc_widx  = k_q[PIECE_W-1:0];
        pc_wdata = pc_rdata;
        k_d      = k_q - CNT_W'(1);
        if ((k_q - CNT_W'(1)) > i_q) begin
          pc_re   = 1'b1;
          pc_ridx = PIECE_W'(k_q - CNT_W'(2));
        end else begin
          state_d = ST_INSERT;
        end
      end

      ST_INSERT: begin
        pc_we    = 1'b1;
        pc_widx  = i_q[PIECE_W-1:0];
        pc_wdata = '{start: off_q, size: len_q, handle: tag_q};
        c_d      = c_q + CNT_W'(1);
        if (last_q) begin
          seen_d[sl] = 1'b1;
        end
        if (seen_new && (recv_new == total_new)) begin
          total_d     = total_new;
          valid_d[sl] = 1'b0;
          seen_d[sl]  = 1'b0;
          age_cmd     = '{op: AGE_REMOVE, slot: sl};
          k_d         = '0;
          state_d     = ST_EMIT_RD;
        end else begin
          rec_we    = 1'b1;
          rec_wdata = '{id: rec_q.id, received: recv_new, total: total_new,
                        stamp: ts_q, count: c_q + CNT_W'(1)};
          age_cmd   = '{op: AGE_MOVE, slot: sl};
          status_d  = STAT_PENDING;
          state_d   = ST_RESULT;
        end
      end

      ST_EMIT_RD: begin
        pc_re   = 1'b1;
        pc_ridx = k_q[PIECE_W-1:0];
        state_d = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_user_d = STAT_PIECE;
          out_last_d = (k_q + CNT_W'(1)) == c_q;
          out_data_d = {2'b00, evid_q, ev_q, total_q, pc_rdata.size, pc_rdata.start,
                        pc_rdata.handle, sl};
          k_d        = k_q + CNT_W'(1);
          state_d    = ((k_q + CNT_W'(1)) == c_q) ? ST_IDLE : ST_EMIT_RD;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_user_d = status_q;
          out_last_d = 1'b1;
          out_data_d = {2'b00, evid_q, ev_q, 17'd0,
                        zero_piece ? 16'd0 : len_q,
                        zero_piece ? 16'd0 : off_q,
                        tag_q, sl};
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      seen_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      seen_q  <= seen_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q      <= rec_d;
    c_q        <= c_d;
    i_q        <= i_d;
    k_q        <= k_d;
    prev_q     <= prev_d;
    succ_q     <= succ_d;
    status_q   <= status_d;
    total_q    <= total_d;
    ev_q       <= ev_d;
    evid_q     <= evid_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

`include "fragment_reassembly_tracker_unit_macros.svh"

  // The age list holds exactly the valid slots.
  `FRT_ASSERT(a_age_matches_valid, (CNT_W'($countones(valid_q)) == age_cnt), "age list off")
  // An accepted word always starts with the ageing check.
  `FRT_ASSERT(a_accept_to_age, (in_acc |=> (state_q == ST_AGE)), "ageing skipped")
  // Emission never runs past the stored pieces.
  `FRT_ASSERT(a_emit_in_range, ((state_q == ST_EMIT_LD) |-> (k_q < c_q)), "emit index past count")

endmodule
`default_nettype wire

// File: tb/sv/tb_fragment_reassembly_tracker_unit.sv
`default_nettype none
module tb_fragment_reassembly_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import frt_pkg::*;

  // One input word, split into its fields.
  typedef struct {
    bit        frag;
    bit [15:0] id;
    bit [15:0] off;
    bit [4:0]  hw;
    bit [15:0] plen;
    bit        last;
    bit [31:0] ts;
    bit [15:0] tag;
  } frag_word_t;

  // One result word, split into its fields.
  typedef struct packed {
    bit [2:0]  status;
    bit [3:0]  slot;
    bit [15:0] tag;
    bit [15:0] off;
    bit [15:0] len;
    bit        last;
    bit [16:0] total;
    bit        ev;
    bit [15:0] evid;
  } result_t;

  // A row of the directed table. Rows marked typed carry a hand-written result.
  typedef struct {
    frag_word_t w;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk_i = ~clk_i;

  fragment_reassembly_tracker_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Tracker state as the checker sees it.
  bit [31:0] window_q;
  bit        slot_busy [NUM_SLOTS];
  bit        slot_got_last [NUM_SLOTS];
  bit [15:0] slot_owner [NUM_SLOTS];
  bit [16:0] slot_rcvd [NUM_SLOTS];
  bit [16:0] slot_len [NUM_SLOTS];
  bit [31:0] slot_time [NUM_SLOTS];
  int        slot_pieces [NUM_SLOTS];
  bit [15:0] pc_start [NUM_SLOTS][MAX_PIECES];
  bit [15:0] pc_size [NUM_SLOTS][MAX_PIECES];
  bit [15:0] pc_tag [NUM_SLOTS][MAX_PIECES];
  int        lru_slots [$];

  result_t expected_results [$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int pieces_out = 0;
  int evictions = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  task automatic flag_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic void release_slot(input int s);
    foreach (lru_slots[i]) begin
      if (lru_slots[i] == s) begin
        lru_slots.delete(i);
        break;
      end
    end
    slot_busy[s] = 1'b0;
    slot_got_last[s] = 1'b0;
  endfunction

  function automatic result_t mk(input bit [2:0] st, input bit [3:0] sl,
                                 input bit [15:0] tag, input bit [15:0] off,
                                 input bit [15:0] len, input bit last,
                                 input bit [16:0] total, input bit ev,
                                 input bit [15:0] evid);
    result_t r;
    r.status = st; r.slot = sl; r.tag = tag; r.off = off; r.len = len;
    r.last = last; r.total = total; r.ev = ev; r.evid = evid;
    return r;
  endfunction

  // Applies one word to the tracker state and returns the results it causes.
  function automatic void track_fragment(input frag_word_t w, output result_t rs[$]);
    bit ev;
    bit [15:0] evid;
    bit [3:0] sl;
    bit [15:0] len;
    int s, c, i;
    bit [31:0] d;
    longint span;
    rs = {};
    ev = 1'b0;
    evid = '0;
    sl = 4'(w.id % NUM_SLOTS);
    // Age out the least recently updated slot when its stamp is too far off.
    if (lru_slots.size() > 0) begin
      s = lru_slots[0];
      d = w.ts - slot_time[s];
      span = (d <= 32'h8000_0000) ? longint'(d) : (64'h1_0000_0000 - longint'(d));
      if (span > longint'(window_q)) begin
        ev = 1'b1;
        evid = slot_owner[s];
        evictions++;
        release_slot(s);
      end
    end
    if (!w.frag) begin
      rs.push_back(mk(STAT_NOT_FRAG, sl, w.tag, 0, 0, 1, 0, ev, evid));
      return;
    end
    if (int'(w.plen) < 4 * int'(w.hw)) begin
      rs.push_back(mk(STAT_SHORT, sl, w.tag, 0, 0, 1, 0, ev, evid));
      return;
    end
    len = 16'(int'(w.plen) - 4 * int'(w.hw));
    if (slot_busy[sl] && slot_owner[sl] != w.id) begin
      rs.push_back(mk(STAT_BUSY, sl, w.tag, w.off, len, 1, 0, ev, evid));
      return;
    end
    if (!slot_busy[sl]) begin
      slot_busy[sl] = 1'b1;
      slot_got_last[sl] = 1'b0;
      slot_owner[sl] = w.id;
      slot_rcvd[sl] = '0;
      slot_len[sl] = '0;
      slot_pieces[sl] = 0;
      slot_time[sl] = w.ts;
      lru_slots.push_back(sl);
    end
    c = slot_pieces[sl];
    i = 0;
    while (i < c && pc_start[sl][i] < w.off) i++;
    if (i < c && pc_start[sl][i] == w.off) begin
      rs.push_back(mk(STAT_DUP, sl, w.tag, w.off, len, 1, 0, ev, evid));
      return;
    end
    // Overlap with either neighbor throws the whole packet away.
    if ((i > 0 && int'(pc_start[sl][i-1]) + int'(pc_size[sl][i-1]) > int'(w.off)) ||
        (i < c && int'(w.off) + int'(len) > int'(pc_start[sl][i]))) begin
      release_slot(sl);
      rs.push_back(mk(STAT_OVERLAP, sl, w.tag, w.off, len, 1, 0, ev, evid));
      return;
    end
    if (c >= MAX_PIECES) begin
      rs.push_back(mk(STAT_FULL, sl, w.tag, w.off, len, 1, 0, ev, evid));
      return;
    end
    for (int k = c; k > i; k--) begin
      pc_start[sl][k] = pc_start[sl][k-1];
      pc_size[sl][k] = pc_size[sl][k-1];
      pc_tag[sl][k] = pc_tag[sl][k-1];
    end
    pc_start[sl][i] = w.off;
    pc_size[sl][i] = len;
    pc_tag[sl][i] = w.tag;
    c++;
    slot_pieces[sl] = c;
    slot_rcvd[sl] = slot_rcvd[sl] + 17'(len);
    if (w.last) begin
      slot_len[sl] = 17'(int'(w.off) + int'(len));
      slot_got_last[sl] = 1'b1;
    end
    if (slot_got_last[sl] && slot_rcvd[sl] == slot_len[sl]) begin
      for (int k = 0; k < c; k++)
        rs.push_back(mk(STAT_PIECE, sl, pc_tag[sl][k], pc_start[sl][k], pc_size[sl][k],
                        k + 1 == c, slot_len[sl], ev, evid));
      release_slot(sl);
      return;
    end
    // Still pending: refresh the stamp and make the slot the youngest.
    slot_time[sl] = w.ts;
    foreach (lru_slots[j]) begin
      if (lru_slots[j] == sl) begin
        lru_slots.delete(j);
        break;
      end
    end
    lru_slots.push_back(sl);
    rs.push_back(mk(STAT_PENDING, sl, w.tag, w.off, len, 1, 0, ev, evid));
  endfunction

  function automatic frag_word_t fw(input bit frag, input bit [15:0] id,
                                    input bit [15:0] off, input bit [4:0] hw,
                                    input bit [15:0] plen, input bit last,
                                    input bit [31:0] ts, input bit [15:0] tag);
    frag_word_t w;
    w.frag = frag; w.id = id; w.off = off; w.hw = hw; w.plen = plen;
    w.last = last; w.ts = ts; w.tag = tag;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (calm || r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one word and, once it is taken, queues what it should produce.
  // A typed row replaces the computed results by its hand-written one.
  task automatic send_word(input frag_word_t w, input bit typed = 1'b0,
                           input result_t want = '{default: 0});
    result_t rs[$];
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= w.frag;
    s_axis_tlast <= w.last;
    s_axis_tdata <= {3'b0, w.tag, w.ts, w.plen, w.hw, w.off, w.id};
    do @(posedge clk_i); while (!s_axis_tready);
    words_in++;
    track_fragment(w, rs);
    if (typed) rs = '{want};
    foreach (rs[i]) expected_results.push_back(rs[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Writes the expiry window over APB, then reads it back.
  task automatic set_window(input bit [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_EXPIRY_WINDOW; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    window_q = value;
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) flag_mismatch($sformatf("window read %h, wrote %h", prdata, value));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // A well-formed packet cut into a few adjacent pieces sent in random order,
  // with an occasional repeat, stray word or fully random word mixed in.
  task automatic send_packet(input bit [15:0] id, inout bit [31:0] clock_ticks);
    int n, r;
    int offs[$], lens[$], order[$];
    int base;
    frag_word_t w;
    n = $urandom_range(1, 4);
    base = 0;
    for (int k = 0; k < n; k++) begin
      offs.push_back(base);
      lens.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 20000)
                                               : $urandom_range(1, 200));
      base += lens[k];
      order.push_back(k);
    end
    order.shuffle();
    foreach (order[j]) begin
      int k;
      k = order[j];
      clock_ticks += $urandom_range(0, 30);
      w = fw(1, id, 16'(offs[k]), 0, 0, k == n - 1, clock_ticks, 16'($urandom));
      w.hw = 5'($urandom_range(0, 8));
      w.plen = 16'(lens[k] + 4 * int'(w.hw));
      send_word(w);
      r = $urandom_range(0, 15);
      if (r == 0) begin
        send_word(w);
      end else if (r == 1) begin
        send_word(fw(0, 16'($urandom), 16'($urandom), 5'($urandom), 16'($urandom),
                     1'($urandom), clock_ticks, 16'($urandom)));
      end else if (r == 2) begin
        send_word(fw(1, 16'($urandom), 16'($urandom), 5'($urandom), 16'($urandom),
                     1'($urandom), $urandom, 16'($urandom)));
      end
    end
  endtask

  // Result side: random stalls, and a field-by-field compare of every word taken.
  int stall_left = 0;
  always @(posedge clk_i) begin
    result_t got, exp_r;
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 15);
      if (calm || r >= 4) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= (r == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.slot = m_axis_tdata[3:0];
      got.tag = m_axis_tdata[19:4];
      got.off = m_axis_tdata[35:20];
      got.len = m_axis_tdata[51:36];
      got.total = m_axis_tdata[68:52];
      got.ev = m_axis_tdata[69];
      got.evid = m_axis_tdata[85:70];
      got.last = m_axis_tlast;
      words_out++;
      if (got.status == STAT_PIECE) pieces_out++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %p", got));
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) flag_mismatch($sformatf("got %p, expected %p", got, exp_r));
      end
    end
  end

  // Watchdog: any handshake on either stream or the APB port counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Timeout: no word moved for 5000 cycles");
      $display("TEST FAILED");
      $finish;
    end
  end

  stim_row_t rows[$];
  initial begin
    bit [31:0] ticks;
    result_t none;
    none = '{default: 0};
    window_q = EXPIRY_RESET;
    foreach (slot_busy[i]) begin
      slot_busy[i] = 1'b0;
      slot_got_last[i] = 1'b0;
    end

    // Directed table. The first two rows can be read off at a glance.
    rows.push_back('{fw(0, 16'hFFFF, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
                     mk(STAT_NOT_FRAG, 15, 16'hFFFF, 0, 0, 1, 0, 0, 0)});
    rows.push_back('{fw(1, 3, 16'hFFFF, 31, 123, 1, 32'hFFFF_FFFF, 0), 1'b1,
                     mk(STAT_SHORT, 3, 0, 0, 0, 1, 0, 0, 0)});
    rows.push_back('{fw(1, 5, 0, 5, 120, 0, 10, 16'h1111), 1'b0, none});
    // Same offset again is a duplicate; another id on the same slot is busy.
    rows.push_back('{fw(1, 5, 0, 0, 100, 0, 11, 2), 1'b0, none});
    rows.push_back('{fw(1, 21, 50, 0, 10, 0, 12, 3), 1'b0, none});
    rows.push_back('{fw(1, 5, 100, 0, 100, 1, 13, 4), 1'b0, none});
    // Overlap with the piece before, then with the piece after.
    rows.push_back('{fw(1, 6, 100, 0, 50, 0, 14, 5), 1'b0, none});
    rows.push_back('{fw(1, 6, 120, 0, 10, 0, 15, 6), 1'b0, none});
    rows.push_back('{fw(1, 7, 200, 0, 10, 0, 16, 7), 1'b0, none});
    rows.push_back('{fw(1, 7, 195, 0, 10, 0, 17, 8), 1'b0, none});
    // Largest offset and length, completed to the largest total.
    rows.push_back('{fw(1, 9, 16'hFFFF, 0, 16'hFFFF, 1, 18, 16'hFFFF), 1'b0, none});
    rows.push_back('{fw(1, 9, 0, 0, 16'hFFFF, 0, 19, 0), 1'b0, none});
    // Empty body marked last completes at once; an empty piece past zero waits.
    rows.push_back('{fw(1, 10, 0, 0, 0, 1, 20, 16'hAAAA), 1'b0, none});
    rows.push_back('{fw(1, 11, 40, 31, 124, 1, 21, 16'h5555), 1'b0, none});
    // A second last flag gives the same total, and the packet completes.
    rows.push_back('{fw(1, 11, 0, 0, 40, 1, 22, 9), 1'b0, none});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    calm = 1'b1;
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    calm = 1'b0;
    // Fill one slot to its piece limit, then one more is refused as full.
    for (int k = 0; k <= MAX_PIECES; k++)
      send_word(fw(1, 12, 16'(k * 10), 1, 14, 0, 32'(30 + k), 16'(k)));
    // A far-away stamp ages out the oldest slot.
    send_word(fw(0, 0, 0, 0, 0, 0, 32'h8000_0020, 0));
    drain();
    set_window(32'd0);
    send_word(fw(0, 1, 0, 0, 0, 0, 32'h8000_0020, 1));
    drain();

    // Random phases over several expiry windows, the extremes included.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_window(EXPIRY_RESET);
        1: set_window(32'd150);
        2: set_window(32'hFFFF_FFFF);
        default: set_window(32'd0);
      endcase
      ticks = $urandom;
      calm = (phase == 2);
      for (int k = 0; k < 8; k++) begin
        send_packet(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                    ticks);
        if (phase == 1 && $urandom_range(0, 3) == 0) ticks += $urandom_range(100, 400);
      end
      drain();
    end

    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d input words, %0d result words (%0d reassembled pieces),",
             words_in, words_out, pieces_out);
    $display("%0d slot evictions, over five expiry window settings.", evictions);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
